[rtl/im2col_address_generator_top_defines.svh]
// Assertion macros shared by the im2col address generator checker.
// Bodies expect clk and rst_n to be visible where the macro is used.
`ifndef IM2COL_ADDRESS_GENERATOR_TOP_DEFINES_SVH
`define IM2COL_ADDRESS_GENERATOR_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define I2CAG_ASSERT_NOW(label, ant, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error(msg);

// fixed-delay implication, disabled in reset
`define I2CAG_ASSERT_DELAY(label, ant, n, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> ##n (cons)) \
    else $error(msg);

`endif

[rtl/i2cag_pkg.sv]
// Types, widths and register codes for the im2col address generator.
// No dependencies; imported by every module of the block.
package i2cag_pkg;

  localparam int BATCH_W    = 8;
  localparam int POS_W      = 10;
  localparam int PATCH_W    = 18;
  localparam int ADDR_W     = 38;
  localparam int SMALL_W    = 4;
  localparam int DIM_W      = 11;

  localparam int DIVIDEND_W         = PATCH_W;
  localparam int DIVISOR_W          = DIM_W;
  localparam int DIV_BITS_PER_STAGE = 3;
  localparam int DIV_STAGES         = DIVIDEND_W / DIV_BITS_PER_STAGE;
  localparam int ADDR_STAGES        = 4;
  localparam int PIPE_LATENCY       = 2 * DIV_STAGES + ADDR_STAGES;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 5;
  localparam int REG_IDX_W  = CFG_ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_STRIDE       = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PAD          = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_KERNEL_DIM   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_CHANNELS_IN  = 3'd5;

  localparam logic [SMALL_W-1:0] RST_STRIDE       = 4'd1;
  localparam logic [SMALL_W-1:0] RST_PAD          = 4'd0;
  localparam logic [SMALL_W-1:0] RST_KERNEL_DIM   = 4'd3;
  localparam logic [DIM_W-1:0]   RST_IMAGE_HEIGHT = 11'd1;
  localparam logic [DIM_W-1:0]   RST_IMAGE_WIDTH  = 11'd1;
  localparam logic [DIM_W-1:0]   RST_CHANNELS_IN  = 11'd1;

  typedef struct packed {
    logic [BATCH_W-1:0] batch_index;
    logic [POS_W-1:0]   out_row;
    logic [POS_W-1:0]   out_col;
    logic [PATCH_W-1:0] patch_col;
  } in_t;

  typedef struct packed {
    logic [ADDR_W-1:0] src_address;
    logic              is_padding;
  } res_t;

  typedef struct packed {
    logic [SMALL_W-1:0] stride;
    logic [SMALL_W-1:0] pad;
    logic [SMALL_W-1:0] kernel_dim;
    logic [DIM_W-1:0]   image_height;
    logic [DIM_W-1:0]   image_width;
    logic [DIM_W-1:0]   channels_in;
    logic [SMALL_W-1:0] kernel_eff;   // zero read as one
    logic [DIM_W-1:0]   chan_eff;     // zero read as one
  } cfg_t;

  // fields carried alongside the divider pipelines
  typedef struct packed {
    logic [BATCH_W-1:0] batch_index;
    logic [POS_W-1:0]   out_row;
    logic [POS_W-1:0]   out_col;
    logic [DIM_W-1:0]   chan;
  } side_t;

endpackage

[rtl/im2col_address_generator_top.sv]
// Top level of the im2col address generator: config registers, two divider
// pipelines and the address pipeline. Depends on i2cag_pkg and the three submodules.
//
// Usage:
//   Input: drive in_data and raise start; a transaction is taken at each rising
//   edge with start high and busy low. busy is high during reset and clears once
//   reset is released; then one transaction per cycle is taken back to back.
//   Output: out_valid strobes for one cycle with out_data (source address and
//   padding flag). Results come out in input order, one per transaction.
//   Pipeline: 6 stages for patch column / channels, 6 for the kernel split
//   (3 quotient bits per stage each), 4 for coordinates and address math.
//   Throughput: one transaction per cycle.
//   Configuration: APB writes, pready tied high; write only while no
//   transaction is in flight.
//   Reset: rst_n low clears all in-flight transactions and loads register
//   defaults. The receiver cannot stall; results are never held.
module im2col_address_generator_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  i2cag_pkg::in_t                   in_data,
  output logic                             out_valid,
  output i2cag_pkg::res_t                  out_data,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [i2cag_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [i2cag_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [i2cag_pkg::CFG_DATA_W-1:0] prdata,
  output logic                             pready
);
  import i2cag_pkg::*;

  cfg_t                  cfg;
  logic                  busy_r;
  logic                  accept;
  side_t                 side_in, side_mid, side_mid_out, side_out;
  logic                  vld_mid, vld_out;
  logic [DIVIDEND_W-1:0] pix, kr;
  logic [DIVISOR_W-1:0]  chan, kc_wide;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign accept = start & ~busy_r;

  i2cag_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  always_comb begin
    side_in.batch_index = in_data.batch_index;
    side_in.out_row     = in_data.out_row;
    side_in.out_col     = in_data.out_col;
    side_in.chan        = '0;
  end

  // patch column -> pixel index, channel
  i2cag_div_pipe u_div_chan (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept),
    .dividend  (in_data.patch_col),
    .divisor   (cfg.chan_eff),
    .in_side   (side_in),
    .out_valid (vld_mid),
    .quotient  (pix),
    .remainder (chan),
    .out_side  (side_mid)
  );

  always_comb begin
    side_mid_out      = side_mid;
    side_mid_out.chan = chan;
  end

  // pixel index -> kernel row, kernel column
  i2cag_div_pipe u_div_kern (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vld_mid),
    .dividend  (pix),
    .divisor   (DIVISOR_W'(cfg.kernel_eff)),
    .in_side   (side_mid_out),
    .out_valid (vld_out),
    .quotient  (kr),
    .remainder (kc_wide),
    .out_side  (side_out)
  );

  i2cag_addr_pipe u_addr (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (vld_out),
    .kr        (kr),
    .kc        (kc_wide[SMALL_W-1:0]),
    .in_side   (side_out),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

[rtl/i2cag_cfg_regs.sv]
// APB-style configuration registers for the im2col address generator.
// Depends on i2cag_pkg.
module i2cag_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [i2cag_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [i2cag_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [i2cag_pkg::CFG_DATA_W-1:0] prdata,
  output logic                             pready,
  output i2cag_pkg::cfg_t                  cfg
);
  import i2cag_pkg::*;

  logic [SMALL_W-1:0]   stride_r;
  logic [SMALL_W-1:0]   pad_r;
  logic [SMALL_W-1:0]   kernel_dim_r;
  logic [DIM_W-1:0]     image_height_r;
  logic [DIM_W-1:0]     image_width_r;
  logic [DIM_W-1:0]     channels_in_r;
  logic [REG_IDX_W-1:0] idx;
  logic                 wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[CFG_ADDR_W-1:2];
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stride_r       <= RST_STRIDE;
      pad_r          <= RST_PAD;
      kernel_dim_r   <= RST_KERNEL_DIM;
      image_height_r <= RST_IMAGE_HEIGHT;
      image_width_r  <= RST_IMAGE_WIDTH;
      channels_in_r  <= RST_CHANNELS_IN;
    end else if (wr_en) begin
      unique case (idx)
        REG_STRIDE:       stride_r       <= pwdata[SMALL_W-1:0];
        REG_PAD:          pad_r          <= pwdata[SMALL_W-1:0];
        REG_KERNEL_DIM:   kernel_dim_r   <= pwdata[SMALL_W-1:0];
        REG_IMAGE_HEIGHT: image_height_r <= pwdata[DIM_W-1:0];
        REG_IMAGE_WIDTH:  image_width_r  <= pwdata[DIM_W-1:0];
        REG_CHANNELS_IN:  channels_in_r  <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_STRIDE:       prdata = {{(CFG_DATA_W-SMALL_W){1'b0}}, stride_r};
      REG_PAD:          prdata = {{(CFG_DATA_W-SMALL_W){1'b0}}, pad_r};
      REG_KERNEL_DIM:   prdata = {{(CFG_DATA_W-SMALL_W){1'b0}}, kernel_dim_r};
      REG_IMAGE_HEIGHT: prdata = {{(CFG_DATA_W-DIM_W){1'b0}}, image_height_r};
      REG_IMAGE_WIDTH:  prdata = {{(CFG_DATA_W-DIM_W){1'b0}}, image_width_r};
      REG_CHANNELS_IN:  prdata = {{(CFG_DATA_W-DIM_W){1'b0}}, channels_in_r};
      default:          prdata = '0;
    endcase
  end

  always_comb begin
    cfg.stride       = stride_r;
    cfg.pad          = pad_r;
    cfg.kernel_dim   = kernel_dim_r;
    cfg.image_height = image_height_r;
    cfg.image_width  = image_width_r;
    cfg.channels_in  = channels_in_r;
    cfg.kernel_eff   = (kernel_dim_r == '0) ? SMALL_W'(1) : kernel_dim_r;
    cfg.chan_eff     = (channels_in_r == '0) ? DIM_W'(1) : channels_in_r;
  end

endmodule

[rtl/i2cag_div_pipe.sv]
// Pipelined restoring divider, a few quotient bits per stage, sideband carried along.
// Depends on i2cag_pkg. Divisor must be nonzero and held stable while items are in flight.
module i2cag_div_pipe (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic [i2cag_pkg::DIVIDEND_W-1:0] dividend,
  input  logic [i2cag_pkg::DIVISOR_W-1:0]  divisor,
  input  i2cag_pkg::side_t                 in_side,
  output logic                             out_valid,
  output logic [i2cag_pkg::DIVIDEND_W-1:0] quotient,
  output logic [i2cag_pkg::DIVISOR_W-1:0]  remainder,
  output i2cag_pkg::side_t                 out_side
);
  import i2cag_pkg::*;

  logic [DIV_STAGES-1:0] vld_r;
  logic [DIVIDEND_W-1:0] rq_r   [DIV_STAGES];  // dividend shifts out, quotient shifts in
  logic [DIVISOR_W-1:0]  rem_r  [DIV_STAGES];
  side_t                 side_r [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : gen_stage
    logic                  vld_in;
    logic [DIVIDEND_W-1:0] rq_in;
    logic [DIVISOR_W-1:0]  rem_in;
    side_t                 side_in;
    logic [DIVIDEND_W-1:0] rq_nxt;
    logic [DIVISOR_W-1:0]  rem_nxt;

    if (s == 0) begin : gen_head
      assign vld_in  = in_valid;
      assign rq_in   = dividend;
      assign rem_in  = '0;
      assign side_in = in_side;
    end else begin : gen_body
      assign vld_in  = vld_r[s-1];
      assign rq_in   = rq_r[s-1];
      assign rem_in  = rem_r[s-1];
      assign side_in = side_r[s-1];
    end

    always_comb begin
      logic [DIVISOR_W:0] trial;
      rq_nxt  = rq_in;
      rem_nxt = rem_in;
      for (int b = 0; b < DIV_BITS_PER_STAGE; b++) begin
        trial  = {rem_nxt, rq_nxt[DIVIDEND_W-1]};
        rq_nxt = {rq_nxt[DIVIDEND_W-2:0], 1'b0};
        if (trial >= {1'b0, divisor}) begin
          trial     = trial - {1'b0, divisor};
          rq_nxt[0] = 1'b1;
        end
        rem_nxt = trial[DIVISOR_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      rq_r[s]   <= rq_nxt;
      rem_r[s]  <= rem_nxt;
      side_r[s] <= side_in;
    end
  end

  assign out_valid = vld_r[DIV_STAGES-1];
  assign quotient  = rq_r[DIV_STAGES-1];
  assign remainder = rem_r[DIV_STAGES-1];
  assign out_side  = side_r[DIV_STAGES-1];

endmodule

[rtl/i2cag_addr_pipe.sv]
// Source pixel, bounds check and NHWC address: four register stages.
// Depends on i2cag_pkg; fed by the kernel-offset divider.
module i2cag_addr_pipe (
  input  logic                          clk,
  input  logic                          rst_n,
  input  i2cag_pkg::cfg_t               cfg,
  input  logic                          in_valid,
  input  logic [i2cag_pkg::PATCH_W-1:0] kr,
  input  logic [i2cag_pkg::SMALL_W-1:0] kc,
  input  i2cag_pkg::side_t              in_side,
  output logic                          out_valid,
  output i2cag_pkg::res_t               out_data
);
  import i2cag_pkg::*;

  localparam int PROD_W = POS_W + SMALL_W;
  localparam int SPOS_W = PATCH_W + 2;       // signed pixel coordinate
  localparam int A1_W   = BATCH_W + DIM_W + 1;
  localparam int A2_W   = A1_W + DIM_W + 1;

  // stage A: pixel coordinates and padding flag
  logic [PROD_W-1:0]  rprod, cprod;
  logic [SPOS_W-1:0]  row_nxt, col_nxt;
  logic               outside_nxt;
  logic               vld_a_r, pad_a_r;
  logic [DIM_W-1:0]   row_a_r, col_a_r, chan_a_r;
  logic [BATCH_W-1:0] batch_a_r;

  assign rprod   = PROD_W'(in_side.out_row) * PROD_W'(cfg.stride);
  assign cprod   = PROD_W'(in_side.out_col) * PROD_W'(cfg.stride);
  assign row_nxt = SPOS_W'(kr) + SPOS_W'(rprod) - SPOS_W'(cfg.pad);
  assign col_nxt = SPOS_W'(kc) + SPOS_W'(cprod) - SPOS_W'(cfg.pad);
  // a negative coordinate also reads as huge unsigned; sign bit kept for clarity
  assign outside_nxt = row_nxt[SPOS_W-1] | col_nxt[SPOS_W-1] |
                       (row_nxt >= SPOS_W'(cfg.image_height)) |
                       (col_nxt >= SPOS_W'(cfg.image_width));

  // stage B: batch*H + row
  logic [A1_W-1:0]  a1_nxt, a1_b_r;
  logic             vld_b_r, pad_b_r;
  logic [DIM_W-1:0] col_b_r, chan_b_r;

  assign a1_nxt = A1_W'(batch_a_r) * A1_W'(cfg.image_height) + A1_W'(row_a_r);

  // stage C: (...)*W + col
  logic [A2_W-1:0]  a2_nxt, a2_c_r;
  logic             vld_c_r, pad_c_r;
  logic [DIM_W-1:0] chan_c_r;

  assign a2_nxt = A2_W'(a1_b_r) * A2_W'(cfg.image_width) + A2_W'(col_b_r);

  // stage D: (...)*Cin + channel, wraps at the address width
  logic [ADDR_W-1:0] a3_nxt;
  logic              out_valid_r;
  res_t              out_data_r;

  assign a3_nxt = ADDR_W'(a2_c_r) * ADDR_W'(cfg.channels_in) + ADDR_W'(chan_c_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r     <= 1'b0;
      vld_b_r     <= 1'b0;
      vld_c_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      vld_a_r     <= in_valid;
      vld_b_r     <= vld_a_r;
      vld_c_r     <= vld_b_r;
      out_valid_r <= vld_c_r;
    end
  end

  always_ff @(posedge clk) begin
    pad_a_r   <= outside_nxt;
    row_a_r   <= row_nxt[DIM_W-1:0];
    col_a_r   <= col_nxt[DIM_W-1:0];
    chan_a_r  <= in_side.chan;
    batch_a_r <= in_side.batch_index;

    a1_b_r    <= a1_nxt;
    pad_b_r   <= pad_a_r;
    col_b_r   <= col_a_r;
    chan_b_r  <= chan_a_r;

    a2_c_r    <= a2_nxt;
    pad_c_r   <= pad_b_r;
    chan_c_r  <= chan_b_r;

    out_data_r.src_address <= pad_c_r ? '0 : a3_nxt;
    out_data_r.is_padding  <= pad_c_r;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[rtl/i2cag_checker.sv]
// Port-level checks for the im2col address generator, bound to the top level.
// Depends on i2cag_pkg and im2col_address_generator_top_defines.svh.
`include "im2col_address_generator_top_defines.svh"

module i2cag_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            start,
  input logic            busy,
  input logic            out_valid,
  input i2cag_pkg::res_t out_data
);
  import i2cag_pkg::*;

  `I2CAG_ASSERT_NOW(a_pad_zero_addr, out_valid && out_data.is_padding, out_data.src_address == '0, "padding result with nonzero address")
  `I2CAG_ASSERT_DELAY(a_result_follows, start && !busy, PIPE_LATENCY, out_valid, "accepted transaction produced no result")
  `I2CAG_ASSERT_NOW(a_no_spurious, out_valid, $past(start && !busy, PIPE_LATENCY), "result without a matching transaction")
  `I2CAG_ASSERT_NOW(a_ready_after_reset, $past(rst_n), !busy, "busy raised outside reset recovery")

endmodule

bind im2col_address_generator_top i2cag_checker u_i2cag_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);

[tb/tb.sv]
// Self-checking testbench for im2col_address_generator_top: directed plan, then random
// transactions under several register settings, each result checked against model or plan.
// Depends on i2cag_pkg and the RTL of the block.
module tb;
  import i2cag_pkg::*;

  typedef enum {STEP_ITEM, STEP_CFG} step_kind_t;

  typedef struct {
    step_kind_t           kind;
    logic [REG_IDX_W-1:0] idx;
    int unsigned          val;
    in_t                  item;
    bit                   has_want;
    res_t                 want;
  } dir_step_t;

  typedef struct {
    int unsigned stride;
    int unsigned pad;
    int unsigned kdim;
    int unsigned height;
    int unsigned width;
    int unsigned chan;
  } geom_t;

  localparam res_t PAD_RES = '{src_address: '0, is_padding: 1'b1};
  localparam int PHASE_ITEMS = 215;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  in_t                   in_data;
  logic                  out_valid;
  res_t                  out_data;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // shadow of the block's registers
  logic [SMALL_W-1:0] cf_stride;
  logic [SMALL_W-1:0] cf_pad;
  logic [SMALL_W-1:0] cf_kdim;
  logic [DIM_W-1:0]   cf_height;
  logic [DIM_W-1:0]   cf_width;
  logic [DIM_W-1:0]   cf_chan;

  res_t      addr_expect_q[$];
  dir_step_t dir_plan[$];
  int        err_count;

  im2col_address_generator_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("FAILURE");
    $finish;
  end

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("MISMATCH %s: got 0x%0h expected 0x%0h at %0t", what, got, want, $time);
    err_count++;
  endtask

  function automatic res_t predict_src(in_t it);
    longint k, cin, ch, pix, kc, kr, row, col, a;
    res_t   r;
    k   = (cf_kdim == 0) ? 64'sd1 : longint'(cf_kdim);
    cin = (cf_chan == 0) ? 64'sd1 : longint'(cf_chan);
    ch  = longint'(it.patch_col) % cin;
    pix = longint'(it.patch_col) / cin;
    kc  = pix % k;
    kr  = pix / k;
    row = kr + longint'(it.out_row) * longint'(cf_stride) - longint'(cf_pad);
    col = kc + longint'(it.out_col) * longint'(cf_stride) - longint'(cf_pad);
    if (row < 0 || col < 0 || row >= longint'(cf_height) || col >= longint'(cf_width)) begin
      r = PAD_RES;
    end else begin
      // raw channels_in scales the address even when it is zero
      a = longint'(it.batch_index) * longint'(cf_height) + row;
      a = a * longint'(cf_width) + col;
      a = a * longint'(cf_chan) + ch;
      r.src_address = a[ADDR_W-1:0];
      r.is_padding  = 1'b0;
    end
    return r;
  endfunction

  function automatic in_t mk_item(int unsigned b, int unsigned r, int unsigned c,
                                  int unsigned p);
    in_t it;
    it.batch_index = BATCH_W'(b);
    it.out_row     = POS_W'(r);
    it.out_col     = POS_W'(c);
    it.patch_col   = PATCH_W'(p);
    return it;
  endfunction

  // mostly positions that land on or near the image, with patch columns inside the patch
  function automatic in_t make_random_item(bit shaped);
    in_t         it;
    int unsigned rlim, plim, k, cin;
    it.batch_index = BATCH_W'($urandom);
    it.out_row     = POS_W'($urandom);
    it.out_col     = POS_W'($urandom);
    it.patch_col   = PATCH_W'($urandom);
    if (shaped) begin
      k    = (cf_kdim == 0) ? 1 : cf_kdim;
      cin  = (cf_chan == 0) ? 1 : cf_chan;
      plim = k * k * cin - 1;
      if (plim > 262143) plim = 262143;
      rlim = (cf_stride == 0) ? 1023 : (cf_height + cf_pad) / cf_stride;
      if (rlim > 1023) rlim = 1023;
      it.out_row   = POS_W'($urandom_range(0, rlim));
      rlim = (cf_stride == 0) ? 1023 : (cf_width + cf_pad) / cf_stride;
      if (rlim > 1023) rlim = 1023;
      it.out_col   = POS_W'($urandom_range(0, rlim));
      it.patch_col = PATCH_W'($urandom_range(0, plim));
    end
    return it;
  endfunction

  task automatic wait_addr_drain;
    while (addr_expect_q.size() != 0) @(posedge clk);
  endtask

  // quiesce the input, let the pipe empty, then write the register and read it back
  task automatic write_cfg_reg(logic [REG_IDX_W-1:0] idx, int unsigned val);
    logic [CFG_DATA_W-1:0] wmask, wv, rd;
    @(negedge clk);
    start <= 1'b0;
    wait_addr_drain();
    wmask = (idx <= REG_KERNEL_DIM) ? 32'h0000_000F : 32'h0000_07FF;
    wv    = ($urandom & ~wmask) | (val & wmask);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= wv;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    unique case (idx)
      REG_STRIDE:       cf_stride = wv[SMALL_W-1:0];
      REG_PAD:          cf_pad    = wv[SMALL_W-1:0];
      REG_KERNEL_DIM:   cf_kdim   = wv[SMALL_W-1:0];
      REG_IMAGE_HEIGHT: cf_height = wv[DIM_W-1:0];
      REG_IMAGE_WIDTH:  cf_width  = wv[DIM_W-1:0];
      REG_CHANNELS_IN:  cf_chan   = wv[DIM_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    if (rd !== (wv & wmask)) report_mismatch($sformatf("readback reg %0d", idx), rd, wv & wmask);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic issue_item(in_t it, int idle_pct, bit has_want, res_t want);
    while ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start   <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy);
    addr_expect_q.push_back(has_want ? want : predict_src(it));
  endtask

  task automatic write_geometry(geom_t g);
    write_cfg_reg(REG_STRIDE, g.stride);
    write_cfg_reg(REG_PAD, g.pad);
    write_cfg_reg(REG_KERNEL_DIM, g.kdim);
    write_cfg_reg(REG_IMAGE_HEIGHT, g.height);
    write_cfg_reg(REG_IMAGE_WIDTH, g.width);
    write_cfg_reg(REG_CHANNELS_IN, g.chan);
  endtask

  function automatic void plan_item(in_t it, bit has_want, res_t want);
    dir_step_t s;
    s.kind     = STEP_ITEM;
    s.idx      = REG_STRIDE;
    s.val      = 0;
    s.item     = it;
    s.has_want = has_want;
    s.want     = want;
    dir_plan.push_back(s);
  endfunction

  function automatic void plan_cfg(logic [REG_IDX_W-1:0] idx, int unsigned val);
    dir_step_t s;
    s.kind     = STEP_CFG;
    s.idx      = idx;
    s.val      = val;
    s.item     = '0;
    s.has_want = 1'b0;
    s.want     = '0;
    dir_plan.push_back(s);
  endfunction

  always @(posedge clk) begin : result_check
    res_t want;
    if (rst_n && out_valid) begin
      if (addr_expect_q.size() == 0) begin
        report_mismatch("result with no transaction pending", out_data, 0);
      end else begin
        want = addr_expect_q.pop_front();
        if (out_data.src_address !== want.src_address)
          report_mismatch("src_address", out_data.src_address, want.src_address);
        if (out_data.is_padding !== want.is_padding)
          report_mismatch("is_padding", out_data.is_padding, want.is_padding);
      end
    end
  end

  initial begin
    geom_t phase_geom[8];
    int    idle_pct;
    int    drain_cyc;

    err_count = 0;
    rst_n     = 1'b0;
    start     = 1'b0;
    in_data   = '0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    cf_stride = RST_STRIDE;
    cf_pad    = RST_PAD;
    cf_kdim   = RST_KERNEL_DIM;
    cf_height = RST_IMAGE_HEIGHT;
    cf_width  = RST_IMAGE_WIDTH;
    cf_chan   = RST_CHANNELS_IN;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // reset geometry is a 1x1x1 image: only pixel (0,0) is inside
    plan_item(mk_item(0, 0, 0, 0), 1'b1, '{src_address: '0, is_padding: 1'b0});
    plan_item(mk_item(255, 0, 0, 0), 1'b1, '{src_address: 38'd255, is_padding: 1'b0});
    plan_item(mk_item(0, 0, 0, 1), 1'b1, PAD_RES);
    plan_item(mk_item(0, 1023, 0, 0), 1'b1, PAD_RES);
    plan_item(mk_item(0, 0, 1023, 0), 1'b1, PAD_RES);
    plan_item(mk_item(0, 0, 0, 262143), 1'b1, PAD_RES);
    plan_item(mk_item(255, 1023, 1023, 262143), 1'b1, PAD_RES);
    // zero height, then zero width: all padding
    plan_cfg(REG_IMAGE_HEIGHT, 0);
    plan_item(mk_item(0, 0, 0, 0), 1'b1, PAD_RES);
    plan_cfg(REG_IMAGE_HEIGHT, 2047);
    plan_cfg(REG_IMAGE_WIDTH, 0);
    plan_item(mk_item(17, 0, 0, 0), 1'b1, PAD_RES);
    // zero kernel and zero channels read as one for the split
    plan_cfg(REG_IMAGE_WIDTH, 2047);
    plan_cfg(REG_KERNEL_DIM, 0);
    plan_cfg(REG_CHANNELS_IN, 0);
    plan_item(mk_item(3, 2, 1, 5), 1'b0, '0);
    plan_item(mk_item(255, 1023, 1023, 262143), 1'b0, '0);
    // zero stride, pad above range
    plan_cfg(REG_STRIDE, 0);
    plan_cfg(REG_PAD, 15);
    plan_item(mk_item(9, 1023, 1023, 20), 1'b0, '0);
    plan_item(mk_item(1, 500, 7, 15), 1'b0, '0);
    // large geometry, address wraps at 38 bits
    plan_cfg(REG_STRIDE, 15);
    plan_cfg(REG_PAD, 14);
    plan_cfg(REG_KERNEL_DIM, 15);
    plan_cfg(REG_CHANNELS_IN, 2047);
    plan_item(mk_item(255, 136, 136, 230399), 1'b0, '0);
    plan_item(mk_item(255, 1023, 1023, 262143), 1'b0, '0);
    plan_item(mk_item(0, 0, 0, 0), 1'b1, PAD_RES);

    foreach (dir_plan[i]) begin
      if (dir_plan[i].kind == STEP_CFG)
        write_cfg_reg(dir_plan[i].idx, dir_plan[i].val);
      else
        issue_item(dir_plan[i].item, 16, dir_plan[i].has_want, dir_plan[i].want);
    end

    phase_geom[0] = '{1, 0, 1, 1, 1, 1};
    phase_geom[1] = '{1, 1, 3, 8, 8, 4};
    phase_geom[2] = '{2, 0, 3, 16, 12, 3};
    phase_geom[3] = '{$urandom_range(1, 4), $urandom_range(0, 7), 2 * $urandom_range(0, 7) + 1,
                      $urandom_range(1, 40), $urandom_range(1, 40), $urandom_range(1, 64)};
    phase_geom[4] = '{15, 14, 15, 1024, 1024, 1024};
    phase_geom[5] = '{15, 15, 15, 2047, 2047, 2047};
    phase_geom[6] = '{0, 3, 0, 5, 7, 0};
    phase_geom[7] = '{$urandom_range(1, 15), $urandom_range(0, 14), $urandom_range(1, 15),
                      $urandom_range(1, 1024), $urandom_range(1, 1024), $urandom_range(1, 1024)};

    for (int ph = 0; ph < 8; ph++) begin
      idle_pct = (ph < 3) ? 16 : ((ph < 6) ? 46 : 0);
      write_geometry(phase_geom[ph]);
      for (int n = 0; n < PHASE_ITEMS; n++)
        issue_item(make_random_item($urandom_range(0, 99) < 80), idle_pct, 1'b0, '0);
    end
    @(negedge clk);
    start <= 1'b0;

    drain_cyc = 0;
    while (addr_expect_q.size() != 0 && drain_cyc < 20 * PIPE_LATENCY) begin
      @(posedge clk);
      drain_cyc++;
    end
    repeat (PIPE_LATENCY + 4) @(posedge clk);
    if (addr_expect_q.size() != 0)
      report_mismatch("transactions without result", addr_expect_q.size(), 0);

    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[im2col_address_generator_top.f]
+incdir+rtl
rtl/i2cag_pkg.sv
rtl/i2cag_cfg_regs.sv
rtl/i2cag_div_pipe.sv
rtl/i2cag_addr_pipe.sv
rtl/im2col_address_generator_top.sv
rtl/i2cag_checker.sv
tb/tb.sv
